// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL that checks its own logic (included by the serializer core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge outside reset.
`define DWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that trig at one edge implies prop at the next edge.
`define DWS_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- hw/rtl/i2c_dws_pkg.sv -----
// Types, constants and microcode table of the I2C display write serializer.
package i2c_dws_pkg;

  localparam logic [7:0] DEV_ADDR_RESET = 8'h78;
  localparam logic [7:0] CTRL_COMMAND   = 8'h00;
  localparam logic [7:0] CTRL_DATA      = 8'h40;

  localparam int unsigned STEP_W    = 3;
  localparam int unsigned NUM_STEPS = 6;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_STEPS - 1);

  localparam int unsigned SLOT_W = 5;
  // last slot index of a piece
  localparam logic [SLOT_W-1:0] BYTE_SLOT_LAST = SLOT_W'(17);
  localparam logic [SLOT_W-1:0] COND_SLOT_LAST = SLOT_W'(1);

  typedef enum logic [0:0] {
    OP_COMMAND = 1'b0,
    OP_DATA    = 1'b1
  } op_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic ack_phase;
    logic run_end;
  } slot_t;

  typedef enum logic [1:0] {
    PIECE_START = 2'd0,
    PIECE_STOP  = 2'd1,
    PIECE_BYTE  = 2'd2
  } piece_e;

  typedef enum logic [1:0] {
    SRC_ADDR = 2'd0,
    SRC_CTRL = 2'd1,
    SRC_VAL  = 2'd2
  } src_e;

  typedef enum logic [2:0] {
    COND_ALWAYS = 3'd0,
    COND_CLOSE  = 3'd1,
    COND_HEADER = 3'd2,
    COND_TAIL   = 3'd3,
    COND_NEVER  = 3'd4
  } cond_e;

  // Per-request decisions, fixed when the request is taken.
  typedef struct packed {
    logic close_burst;
    logic header;
    logic tail;
  } flags_t;

  // run: step executes when true, else it is skipped.
  // hold: after the last slot of this step the run goes on only when true.
  typedef struct packed {
    piece_e piece;
    src_e   src;
    cond_e  run;
    cond_e  hold;
  } uword_t;

  function automatic uword_t ucode(logic [STEP_W-1:0] pc);
    uword_t w;
    unique case (pc)
      3'd0:    w = '{PIECE_STOP,  SRC_VAL,  COND_CLOSE,  COND_ALWAYS};
      3'd1:    w = '{PIECE_START, SRC_VAL,  COND_HEADER, COND_ALWAYS};
      3'd2:    w = '{PIECE_BYTE,  SRC_ADDR, COND_HEADER, COND_ALWAYS};
      3'd3:    w = '{PIECE_BYTE,  SRC_CTRL, COND_HEADER, COND_ALWAYS};
      3'd4:    w = '{PIECE_BYTE,  SRC_VAL,  COND_ALWAYS, COND_TAIL};
      3'd5:    w = '{PIECE_STOP,  SRC_VAL,  COND_TAIL,   COND_NEVER};
      default: w = '{PIECE_STOP,  SRC_VAL,  COND_NEVER,  COND_NEVER};
    endcase
    return w;
  endfunction

  function automatic logic cond_hit(cond_e c, flags_t f);
    logic hit;
    unique case (c)
      COND_ALWAYS: hit = 1'b1;
      COND_CLOSE:  hit = f.close_burst;
      COND_HEADER: hit = f.header;
      COND_TAIL:   hit = f.tail;
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- hw/rtl/i2c_dws_ifs.sv -----
// Handshake channel interfaces of the I2C display write serializer.
interface i2c_dws_item_if;
  logic                valid;
  logic                ready;
  i2c_dws_pkg::item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2c_dws_slot_if;
  logic                valid;
  logic                ready;
  i2c_dws_pkg::slot_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2c_dws_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2c_display_write_serializer_core.sv -----
// The first line slot of a request is registered after the request is taken and after every
// microcode step of the six-step program that is skipped ahead of the first step that runs.
// One slot per cycle while the sink is ready and no step is being skipped, 18 to 60 slots per
// request; no slot is emitted while a step is skipped or while the request is taken.
// A new request is taken once the last slot of the previous one sits in the output register.
// Reset: no burst open, device address 0x78, output empty; no clearing pass.
module i2c_display_write_serializer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2c_dws_item_if.sink      item_i,
  i2c_dws_cfg_if.sink       cfg_i,
  i2c_dws_slot_if.source    slot_o
);

  `include "assert_macros.svh"

  logic [7:0]                          dev_addr_q;
  logic                                burst_open_q, burst_open_d;
  logic                                busy_q, busy_d;
  logic [i2c_dws_pkg::STEP_W-1:0]      pc_q, pc_d;
  logic [i2c_dws_pkg::SLOT_W-1:0]      slot_q, slot_d;
  i2c_dws_pkg::flags_t                 flags_q, flags_d;
  logic                                op_q;
  logic [7:0]                          val_q;
  logic                                out_valid_q, out_valid_d;
  i2c_dws_pkg::slot_t                  out_q, out_d;

  i2c_dws_pkg::uword_t                 word;
  logic                                accept;
  logic                                run;
  logic                                out_free;
  logic                                emit;
  logic                                piece_done;
  logic [7:0]                          byte_sel;
  logic [3:0]                          bit_idx;
  logic                                phase;

  assign accept       = item_i.valid && item_i.ready;
  assign item_i.ready = !busy_q;
  assign cfg_i.ready  = 1'b1;
  assign slot_o.valid = out_valid_q;
  assign slot_o.data  = out_q;

  assign word     = i2c_dws_pkg::ucode(pc_q);
  assign run      = i2c_dws_pkg::cond_hit(word.run, flags_q);
  assign out_free = !out_valid_q || slot_o.ready;
  assign emit     = busy_q && run && out_free;
  assign bit_idx  = slot_q[4:1];
  assign phase    = slot_q[0];

  always_comb begin
    case (word.src)
      i2c_dws_pkg::SRC_ADDR: byte_sel = dev_addr_q;
      i2c_dws_pkg::SRC_CTRL: byte_sel = (op_q == i2c_dws_pkg::OP_DATA) ?
                                        i2c_dws_pkg::CTRL_DATA : i2c_dws_pkg::CTRL_COMMAND;
      default:               byte_sel = val_q;
    endcase
  end

  // decide per request which optional steps run
  always_comb begin
    flags_d.close_burst = burst_open_q &&
                          ((item_i.data.operation == i2c_dws_pkg::OP_COMMAND) ||
                           item_i.data.first_byte);
    flags_d.header      = (item_i.data.operation == i2c_dws_pkg::OP_COMMAND) ||
                          !(burst_open_q && !item_i.data.first_byte);
    flags_d.tail        = (item_i.data.operation == i2c_dws_pkg::OP_COMMAND) ||
                          item_i.data.last_byte;
  end

  always_comb begin
    piece_done = (word.piece == i2c_dws_pkg::PIECE_BYTE) ?
                 (slot_q == i2c_dws_pkg::BYTE_SLOT_LAST) :
                 (slot_q == i2c_dws_pkg::COND_SLOT_LAST);

    out_d = out_q;
    unique case (word.piece)
      i2c_dws_pkg::PIECE_START: out_d = '{1'b1, !phase, 1'b0, 1'b0};
      i2c_dws_pkg::PIECE_STOP:  out_d = '{1'b1, phase, 1'b0, 1'b0};
      default: begin
        if (bit_idx[3]) begin
          out_d = '{phase, 1'b1, phase, 1'b0};
        end else begin
          out_d = '{phase, byte_sel[~bit_idx[2:0]], 1'b0, 1'b0};
        end
      end
    endcase
    out_d.run_end = piece_done && !i2c_dws_pkg::cond_hit(word.hold, flags_q);
  end

  always_comb begin
    busy_d       = busy_q;
    pc_d         = pc_q;
    slot_d       = slot_q;
    burst_open_d = burst_open_q;
    out_valid_d  = out_valid_q && !slot_o.ready;

    if (accept) begin
      busy_d       = 1'b1;
      pc_d         = '0;
      slot_d       = '0;
      burst_open_d = (item_i.data.operation == i2c_dws_pkg::OP_DATA) &&
                     !item_i.data.last_byte;
    end else if (busy_q) begin
      if (!run) begin
        // skip step
        pc_d = pc_q + 1'b1;
        if (pc_q == i2c_dws_pkg::STEP_LAST) begin
          busy_d = 1'b0;
        end
      end else if (out_free) begin
        out_valid_d = 1'b1;
        if (piece_done) begin
          slot_d = '0;
          pc_d   = pc_q + 1'b1;
          if (out_d.run_end) begin
            busy_d = 1'b0;
          end
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= i2c_dws_pkg::DEV_ADDR_RESET;
      burst_open_q <= 1'b0;
      busy_q       <= 1'b0;
      pc_q         <= '0;
      slot_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        dev_addr_q <= cfg_i.data;
      end
      burst_open_q <= burst_open_d;
      busy_q       <= busy_d;
      pc_q         <= pc_d;
      slot_q       <= slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags_d;
      op_q    <= item_i.data.operation;
      val_q   <= item_i.data.byte_value;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  `DWS_ASSERT(a_pc_range, !busy_q || (pc_q <= i2c_dws_pkg::STEP_LAST), "step counter past program end")
  `DWS_ASSERT_NEXT(a_emit_valid, emit, out_valid_q, "emitted slot not presented")
  `DWS_ASSERT(a_ack_level, !(out_valid_q && out_q.ack_phase) || (out_q.clock_level && out_q.data_level), "ack slot with SCL or SDA low")
  `DWS_ASSERT(a_slot_in_piece, !(busy_q && (slot_q != '0)) || run, "slot count inside a skipped step")

endmodule
